/* rtl/swtm_pkg.sv */
// ----------------------------------------------------------------------------
// swtm_pkg
// Shared widths, constants and types of the sliding window trimmed mean block.
// ----------------------------------------------------------------------------
package swtm_pkg;

  localparam int SAMPLE_W = 10;
  localparam int WINDOW   = 8;

  localparam int AGE_W    = $clog2(WINDOW);
  localparam int IDX_W    = $clog2(WINDOW);
  localparam int LO_IDX   = WINDOW / 4;
  localparam int HI_IDX   = WINDOW - LO_IDX - 1;
  localparam int MID_N    = WINDOW - 2 * LO_IDX;
  localparam int MED_IDX  = WINDOW / 2;
  localparam int DIVISOR  = WINDOW / 2;
  localparam int SUM_W    = $clog2(MID_N * ((2 ** SAMPLE_W) - 1) + 1);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [AGE_W-1:0]    age_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [SUM_W-1:0]    sum_t;

  // one ranked entry: value plus how many samples ago it arrived
  typedef struct packed {
    sample_t val;
    age_t    age;
  } entry_t;

  // handed from each cell to its right-hand neighbour
  typedef struct packed {
    logic   dle;  // oldest entry sits here or further left
    logic   le;   // compacted entry at this place is <= new sample
    entry_t r;    // compacted entry at this place
  } link_t;

  typedef struct packed {
    logic start;
    logic ack;
  } mean_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mean_stat_t;

endpackage

/* rtl/swtm_if.sv */
// ----------------------------------------------------------------------------
// swtm_if
// Valid/ready channels for sample requests and filter results.
// ----------------------------------------------------------------------------
interface swtm_in_if;
  logic              valid;
  logic              ready;
  swtm_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swtm_out_if;
  logic              valid;
  logic              ready;
  swtm_pkg::sample_t trimmed_mean;
  swtm_pkg::sample_t median_value;

  modport source (output valid, output trimmed_mean, output median_value, input ready);
  modport sink   (input valid, input trimmed_mean, input median_value, output ready);
endinterface

/* rtl/swtm_cell.sv */
// ----------------------------------------------------------------------------
// swtm_cell
// One place of the sorted window: drops the oldest entry and inserts the new
// sample in rank order together with its neighbours.
// ----------------------------------------------------------------------------
module swtm_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swtm_pkg::age_t     idx_i,
  input  logic               upd_i,
  input  swtm_pkg::sample_t  x_i,
  input  swtm_pkg::link_t    left_i,
  input  swtm_pkg::entry_t   right_i,
  input  logic               right_vld_i,
  output swtm_pkg::link_t    link_o,
  output swtm_pkg::entry_t   cur_o
);
  import swtm_pkg::*;

  entry_t entry_q, entry_d;
  entry_t r_e;
  logic   del, dle, r_vld, le;

  always_comb begin
    del   = (entry_q.age == AGE_W'(WINDOW - 1));
    dle   = left_i.dle | del;
    // once the oldest is at or left of here, everything shifts down by one
    r_e   = dle ? right_i : entry_q;
    r_vld = !dle || right_vld_i;
    le    = r_vld && (r_e.val <= x_i);

    link_o = '{dle: dle, le: le, r: r_e};

    if (le) begin
      entry_d = '{val: r_e.val, age: age_t'(r_e.age + 1'b1)};
    end else if (left_i.le) begin
      entry_d = '{val: x_i, age: '0};
    end else begin
      entry_d = '{val: left_i.r.val, age: age_t'(left_i.r.age + 1'b1)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '{val: '0, age: idx_i};
    end else if (upd_i) begin
      entry_q <= entry_d;
    end
  end

  assign cur_o = entry_q;

endmodule

/* rtl/swtm_mean.sv */
// ----------------------------------------------------------------------------
// swtm_mean
// Sums the middle ranks one per cycle, then divides by half the window and
// saturates.
// ----------------------------------------------------------------------------
module swtm_mean (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  swtm_pkg::mean_ctrl_t ctrl_i,
  input  swtm_pkg::sample_t    vals_i [swtm_pkg::WINDOW],
  output swtm_pkg::mean_stat_t stat_o,
  output swtm_pkg::sample_t    mean_o
);
  import swtm_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_DONE} state_e;

  state_e                state_q, state_d;
  idx_t                  ptr_q, ptr_d;
  sum_t                  acc_q, acc_d;
  sum_t                  quo_q, quo_d;
  sum_t                  acc_nx;

  always_comb begin
    acc_nx = acc_q + SUM_W'(vals_i[ptr_q]);

    state_d = state_q;
    ptr_d   = ptr_q;
    acc_d   = acc_q;
    quo_d   = quo_q;

    unique case (state_q)
      ST_IDLE: begin
        if (ctrl_i.start) begin
          state_d = ST_SUM;
          ptr_d   = IDX_W'(LO_IDX);
          acc_d   = '0;
        end
      end
      ST_SUM: begin
        acc_d = acc_nx;
        ptr_d = idx_t'(ptr_q + 1'b1);
        if (ptr_q == IDX_W'(HI_IDX)) begin
          state_d = ST_DONE;
          // half of an 8-entry window is a power of two, so this is a shift
          quo_d   = acc_nx / SUM_W'(DIVISOR);
        end
      end
      ST_DONE: begin
        if (ctrl_i.ack) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ptr_q   <= '0;
      acc_q   <= '0;
      quo_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      acc_q   <= acc_d;
      quo_q   <= quo_d;
    end
  end

  assign stat_o.busy = (state_q != ST_IDLE);
  assign stat_o.done = (state_q == ST_DONE);
  // only reachable when the middle part is wider than half the window
  assign mean_o = (|quo_q[SUM_W-1:SAMPLE_W]) ? '1 : quo_q[SAMPLE_W-1:0];

endmodule

/* rtl/sliding_window_trimmed_mean_top.sv */
// ----------------------------------------------------------------------------
// sliding_window_trimmed_mean_top
// Flow: a taken request updates the sorted window; the mean unit then sums
// the middle ranks serially and divides, and the result waits for a free output
// register. No request is taken while the mean unit is busy; the next request
// is taken while the previous result still waits at the output register.
// Reset: the sorted window holds all zeros, no result pending.
// ----------------------------------------------------------------------------
module sliding_window_trimmed_mean_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  swtm_in_if.sink    in_i,
  swtm_out_if.source out_o
);
  import swtm_pkg::*;

  entry_t     cur  [WINDOW];
  link_t      lnk  [WINDOW+1];
  sample_t    vals [WINDOW];
  mean_ctrl_t ctrl;
  mean_stat_t stat;
  sample_t    mean;
  logic       in_acc;
  logic       out_valid_q, out_valid_d;
  sample_t    trimmed_q, median_q;

  assign in_i.ready = !stat.busy;
  assign in_acc     = in_i.valid && in_i.ready;

  assign lnk[0] = '{dle: 1'b0, le: 1'b1, r: '0};

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    entry_t right_e;
    logic   right_vld;

    if (i == WINDOW - 1) begin : g_last
      assign right_e   = cur[i];
      assign right_vld = 1'b0;
    end else begin : g_mid
      assign right_e   = cur[i+1];
      assign right_vld = 1'b1;
    end

    swtm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (AGE_W'(i)),
      .upd_i       (in_acc),
      .x_i         (in_i.sample),
      .left_i      (lnk[i]),
      .right_i     (right_e),
      .right_vld_i (right_vld),
      .link_o      (lnk[i+1]),
      .cur_o       (cur[i])
    );

    assign vals[i] = cur[i].val;
  end

  assign ctrl.start = in_acc;
  assign ctrl.ack   = stat.done && (!out_valid_q || out_o.ready);

  swtm_mean u_mean (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .vals_i (vals),
    .stat_o (stat),
    .mean_o (mean)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (ctrl.ack) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // window is frozen while busy, so the median can be taken at hand-over
  always_ff @(posedge clk_i) begin
    if (ctrl.ack) begin
      trimmed_q <= mean;
      median_q  <= cur[MED_IDX].val;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.trimmed_mean = trimmed_q;
  assign out_o.median_value = median_q;

  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> stat.busy)
    else $error("mean unit not started after request");

  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(stat.done))
    else $error("result loaded without a finished mean");

  a_window_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(cur[MED_IDX]))
    else $error("window changed without a request");

endmodule
